### rtl/page_frame_refcount_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame allocator
// Shared assertion forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_REFCOUNT_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_REFCOUNT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define PFRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfra assertion failed");

// Next-cycle implication.
`define PFRA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfra assertion failed");

`endif

### rtl/pfra_pkg.sv
// ----------------------------------------------------------------------------
// pfra_pkg
// Types, codes and fixed constants of the page frame allocator.
// ----------------------------------------------------------------------------
package pfra_pkg;

  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 8;
  localparam int PAGE_SHIFT  = 12;
  localparam int FN_W        = ADDR_W - PAGE_SHIFT;
  localparam int STATUS_W    = 3;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 40;

  localparam logic [ADDR_W-1:0] BASE_ADDR = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hFFFF_F000;
  localparam logic [CNT_W-1:0]  USED_MARK = 8'd100;

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_FAULT = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_BELOW        = 3'd1,
    ST_NONEXIST     = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_OOM          = 3'd4,
    ST_IN_PLACE     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_OLD  = 2'd1,
    RES_PAGE = 2'd2
  } res_sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREE_START = 1'b0,
    CFG_MEM_END    = 1'b1
  } cfg_idx_t;

  // Controller to datapath.
  typedef struct packed {
    logic     load_req;
    logic     sweep_start;
    logic     fill_only;
    logic     sweep_step;
    logic     scan_start;
    logic     scan_step;
    logic     claim;
    logic     dec_write;
    logic     res_load;
    res_sel_t res_sel;
    status_t  res_status;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    kind_t kind;
    logic  idx_zero;
    logic  hit;
    logic  scan_end;
    logic  below;
    logic  nonexist;
    logic  tracked;
    logic  cnt_zero;
    logic  cnt_one;
  } dp_stat_t;

endpackage

### rtl/pfra_ram.sv
// ----------------------------------------------------------------------------
// pfra_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pfra_dp.sv
// ----------------------------------------------------------------------------
// pfra_dp
// Datapath: config registers, request capture, count store, scan counter
// and result register.
// ----------------------------------------------------------------------------
module pfra_dp import pfra_pkg::*; #(
  parameter int NUM_FRAMES = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data,
  input  logic [TDATA_IN_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]      s_tuser,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  output logic [TDATA_OUT_W-1:0] m_tdata
);

  localparam int                IDX_W    = $clog2(NUM_FRAMES);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_FRAMES - 1);
  localparam logic [FN_W:0]     NUM_FN   = (FN_W+1)'(NUM_FRAMES);

  logic [ADDR_W-1:0] free_start;
  logic [ADDR_W-1:0] mem_end;
  kind_t             req_kind;
  logic [ADDR_W-1:0] req_addr;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  rd_idx;
  logic              pend;
  logic [FN_W-1:0]   lo;
  logic [FN_W-1:0]   span;
  logic              range_ok;
  logic [ADDR_W-1:0] page;
  logic [ADDR_W-1:0] out_page;
  status_t           out_status;

  logic [ADDR_W-1:0] addr_off;
  logic [FN_W-1:0]   fn;
  logic              in_table;
  logic [IDX_W-1:0]  target;
  logic [ADDR_W-1:0] start_off;
  logic [ADDR_W-1:0] span_full;
  logic [FN_W:0]     idx_ext;
  logic [FN_W:0]     hi;
  logic              in_range;
  logic [CNT_W-1:0]  fill;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [CNT_W-1:0]  rd_data;
  logic [ADDR_W-1:0] res_page;

  // Frame number of the request; the low 12 bits never matter.
  assign addr_off = req_addr - BASE_ADDR;
  assign fn       = addr_off[ADDR_W-1:PAGE_SHIFT];
  assign in_table = {1'b0, fn} < NUM_FN;
  assign target   = fn[IDX_W-1:0];

  // Init range: frames lo .. lo+span-1 are freed.
  assign start_off = free_start - BASE_ADDR;
  assign span_full = mem_end - free_start;
  assign idx_ext   = (FN_W+1)'(idx);
  assign hi        = {1'b0, lo} + {1'b0, span};
  assign in_range  = range_ok && (idx_ext >= {1'b0, lo}) && (idx_ext < hi);
  assign fill      = in_range ? '0 : USED_MARK;

  always_comb begin
    ram_we    = cmd.sweep_step | cmd.claim | cmd.dec_write;
    ram_waddr = target;
    ram_wdata = rd_data - CNT_W'(1);
    if (cmd.sweep_step) begin
      ram_waddr = idx;
      ram_wdata = fill;
    end else if (cmd.claim) begin
      ram_waddr = rd_idx;
      ram_wdata = CNT_W'(1);
    end
  end

  assign ram_raddr = cmd.scan_step ? idx : target;

  pfra_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_FRAMES)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_comb begin
    case (cmd.res_sel)
      RES_ZERO: res_page = '0;
      RES_OLD:  res_page = req_addr & PAGE_MASK;
      RES_PAGE: res_page = page;
      default:  res_page = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_start <= '0;
      mem_end    <= '0;
      pend       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FREE_START: free_start <= cfg_data;
          CFG_MEM_END:    mem_end    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.scan_start) begin
        pend <= 1'b0;
      end else if (cmd.scan_step) begin
        pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_kind <= kind_t'(s_tuser);
      req_addr <= s_tdata;
    end
    if (cmd.sweep_start) begin
      lo       <= start_off[ADDR_W-1:PAGE_SHIFT];
      span     <= span_full[ADDR_W-1:PAGE_SHIFT];
      range_ok <= !cmd.fill_only && (mem_end > free_start);
    end
    if (cmd.sweep_start || cmd.scan_start) begin
      idx <= LAST_IDX;
    end else if (cmd.sweep_step || cmd.scan_step) begin
      idx <= idx - IDX_W'(1);
    end
    if (cmd.scan_step) begin
      rd_idx <= idx;
    end
    if (cmd.claim) begin
      page <= BASE_ADDR + (ADDR_W'(rd_idx) << PAGE_SHIFT);
    end
    if (cmd.res_load) begin
      out_page   <= res_page;
      out_status <= cmd.res_status;
    end
  end

  always_comb begin
    stat.kind     = req_kind;
    stat.idx_zero = (idx == '0);
    stat.hit      = pend && (rd_data == '0);
    stat.scan_end = pend && (rd_idx == '0);
    stat.below    = req_addr < BASE_ADDR;
    stat.nonexist = (req_addr > mem_end) || !in_table;
    stat.tracked  = (req_addr >= BASE_ADDR) && in_table;
    stat.cnt_zero = (rd_data == '0);
    stat.cnt_one  = (rd_data == CNT_W'(1));
  end

  assign m_tdata = {(TDATA_OUT_W-ADDR_W-STATUS_W)'(0), out_status, out_page};

endmodule

### rtl/pfra_ctrl.sv
// ----------------------------------------------------------------------------
// pfra_ctrl
// Controller: sequences sweeps, scans and read-modify-writes of the count
// store and owns both handshakes.
// ----------------------------------------------------------------------------
module pfra_ctrl import pfra_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [KIND_W-1:0] s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd
);

  typedef enum logic [2:0] {
    S_PREP,
    S_SWEEP,
    S_IDLE,
    S_TARGET,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t   state;
  state_t   state_next;
  logic     boot;
  logic     claimed;
  logic     out_valid;
  res_sel_t fin_sel;
  status_t  fin_st;

  logic     go_fin;
  res_sel_t fin_sel_next;
  status_t  fin_st_next;
  logic     set_claimed;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd          = '0;
    cmd.res_sel  = fin_sel;
    cmd.res_status = fin_st;
    state_next   = state;
    go_fin       = 1'b0;
    fin_sel_next = RES_ZERO;
    fin_st_next  = ST_OK;
    set_claimed  = 1'b0;
    case (state)
      S_PREP: begin
        cmd.sweep_start = 1'b1;
        cmd.fill_only   = boot;
        state_next      = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.idx_zero) begin
          if (boot) begin
            state_next = S_IDLE;
          end else begin
            go_fin = 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          case (kind_t'(s_tuser))
            KIND_INIT: state_next = S_PREP;
            KIND_ALLOC: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            default: state_next = S_TARGET;
          endcase
        end
      end
      S_TARGET: begin
        case (stat.kind)
          KIND_FREE: begin
            if (stat.below) begin
              go_fin      = 1'b1;
              fin_st_next = ST_BELOW;
            end else if (stat.nonexist) begin
              go_fin      = 1'b1;
              fin_st_next = ST_NONEXIST;
            end else begin
              state_next = S_CHECK;
            end
          end
          KIND_FAULT: begin
            if (stat.tracked) begin
              state_next = S_CHECK;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: go_fin = 1'b1;
        endcase
      end
      S_CHECK: begin
        if (stat.kind == KIND_FREE) begin
          go_fin = 1'b1;
          if (stat.cnt_zero) begin
            fin_st_next = ST_ALREADY_FREE;
          end else begin
            cmd.dec_write = 1'b1;
          end
        end else if (claimed) begin
          // Old page after the new one was claimed: drop one share.
          cmd.dec_write = !stat.cnt_zero;
          go_fin        = 1'b1;
          fin_sel_next  = RES_PAGE;
        end else if (stat.cnt_one) begin
          go_fin       = 1'b1;
          fin_sel_next = RES_OLD;
          fin_st_next  = ST_IN_PLACE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.claim = 1'b1;
          if (stat.kind == KIND_FAULT && stat.tracked) begin
            set_claimed = 1'b1;
            state_next  = S_TARGET;
          end else begin
            go_fin       = 1'b1;
            fin_sel_next = RES_PAGE;
          end
        end else if (stat.scan_end) begin
          go_fin      = 1'b1;
          fin_st_next = ST_OOM;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (go_fin) begin
      state_next = S_FINISH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_PREP;
      boot      <= 1'b1;
      claimed   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SWEEP && stat.idx_zero) begin
        boot <= 1'b0;
      end
      if (cmd.load_req) begin
        claimed <= 1'b0;
      end else if (set_claimed) begin
        claimed <= 1'b1;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (go_fin) begin
      fin_sel <= fin_sel_next;
      fin_st  <= fin_st_next;
    end
  end

endmodule

### rtl/page_frame_refcount_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator
// Physical page frame allocator with an 8-bit share count per 4 KiB frame.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: s_tuser holds the command (init map,
//   allocate, free page, write-protect fault), s_tdata the page address.
//   Each request gives exactly one result on the m_ stream: page address
//   and status code. Frame j sits at byte 0x100000 + j*4096.
//   cfg_we/cfg_index/cfg_data write free_start_addr (0) and
//   memory_end_addr (1); write them only while no request is in flight.
//   The count store has one read and one write port, so the init sweep
//   and the allocation scan visit one frame per cycle.
// Throughput: one request at a time; the next is taken once the previous
//   result sits in the output register, even while m_tready is low.
// Reset: a clearing pass writes 100 into every count;
//   s_tready stays low until it ends, config writes are still taken.
// Stall: the result holds on m_tdata until m_tready; a finished request
//   behind it waits in the controller.
// ----------------------------------------------------------------------------
module page_frame_refcount_allocator import pfra_pkg::*; #(
  parameter int NUM_FRAMES = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data,
  // request stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [31:0] page_addr_in
  input  logic [KIND_W-1:0]      s_tuser,   // [1:0] kind
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata    // [31:0] page_addr_out, [34:32] status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing and handshakes.
  pfra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Count store, address math and result register.
  pfra_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata)
  );

endmodule

### rtl/pfra_checker.sv
// ----------------------------------------------------------------------------
// pfra_checker
// Port-level checks of the page frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_frame_refcount_allocator_assert.svh"

module pfra_checker import pfra_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [TDATA_OUT_W-1:0] m_tdata
);

  logic [STATUS_W-1:0] res_st;
  logic [ADDR_W-1:0]   res_page;
  logic                err_result;
  logic                has_page;

  assign res_st     = m_tdata[34:32];
  assign res_page   = m_tdata[31:0];
  assign err_result = m_tvalid && !(res_st inside {ST_OK, ST_IN_PLACE});
  assign has_page   = m_tvalid && (res_page != '0);

  // The clearing pass runs right after reset.
  `PFRA_ASSERT_IMP(a_busy_after_reset, $fell(rst), !s_tready)

  // One request in flight at a time.
  `PFRA_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // A stalled result holds.
  `PFRA_ASSERT_NXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Error results carry no page.
  `PFRA_ASSERT_IMP(a_no_page_on_error, err_result, res_page == '0)

  // Any page handed out is a frame address at or above the base.
  `PFRA_ASSERT_IMP(a_page_aligned, has_page, res_page[11:0] == '0 && res_page >= BASE_ADDR)

endmodule

bind page_frame_refcount_allocator pfra_checker u_pfra_checker (.*);

### sim/page_frame_refcount_allocator_tb.sv
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator_tb
// Self-checking bench for the page frame allocator. A request stream of init,
// allocate, free and write-protect fault commands drives the block while a
// share-count model in the bench predicts every result. Each result is
// compared field by field with the oldest prediction. Directed cases cover
// reset state, the free and fault rules and extreme memory windows. Random
// phases with fresh windows and random idling follow, plus a long result
// stall that fills the block.
// ----------------------------------------------------------------------------
module page_frame_refcount_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfra_pkg::*;

  localparam int NUM_FRAMES        = 4096;
  localparam int PHASE_COUNT       = 12;
  localparam int PHASE_REQUESTS    = 91;
  localparam int HOLD_OFF_CYCLES   = 600;
  localparam int DRAIN_LIMIT       = 8 * (NUM_FRAMES + 16);
  localparam logic [ADDR_W-1:0] TABLE_END = BASE_ADDR + (32'(NUM_FRAMES) << PAGE_SHIFT);

  typedef struct {
    logic [ADDR_W-1:0] page_addr;
    status_t           status;
  } page_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [ADDR_W-1:0]      cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;   // [31:0] page_addr_in
  logic [KIND_W-1:0]      s_tuser = '0;   // [1:0] kind
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;        // [31:0] page_addr_out, [34:32] status

  // Share-count model and its copy of the two window registers.
  logic [CNT_W-1:0]  frame_share_count [NUM_FRAMES];
  logic [ADDR_W-1:0] model_free_start;
  logic [ADDR_W-1:0] model_mem_end;
  int unsigned       window_lo_frame;

  page_result_t expected_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_req_count = 0;
  int unsigned stall_ack_count = 0;
  int unsigned stall_left = 0;

  int unsigned fail_count = 0;
  int unsigned results_checked = 0;
  int unsigned requests_by_kind [4] = '{default: 0};
  int unsigned status_seen [8] = '{default: 0};

  page_frame_refcount_allocator #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run: every request an
  // out-of-memory scan, every result stalled, plus the clearing pass.
  initial begin
    #250_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // Claim the highest free frame, the way the allocation scan does.
  function automatic bit claim_top_free_frame(output logic [ADDR_W-1:0] page);
    for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
      if (frame_share_count[j] == '0) begin
        frame_share_count[j] = 8'd1;
        page = BASE_ADDR + (32'(j) << PAGE_SHIFT);
        return 1'b1;
      end
    end
    page = '0;
    return 1'b0;
  endfunction

  // Apply one request to the model and return the result it must produce.
  function automatic page_result_t predict_page_result(kind_t kind,
                                                       logic [ADDR_W-1:0] addr);
    page_result_t      res;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] fault_page;
    logic [ADDR_W-1:0] claimed_page;
    logic [ADDR_W-1:0] idx;
    bit                tracked;
    res.page_addr = '0;
    res.status    = ST_OK;
    case (kind)
      KIND_INIT: begin
        foreach (frame_share_count[j]) frame_share_count[j] = USED_MARK;
        // Free the window only when end lies above start; a start below base
        // wraps far past the table and frees nothing.
        if (model_mem_end > model_free_start) begin
          first = (model_free_start - BASE_ADDR) >> PAGE_SHIFT;
          span  = (model_mem_end - model_free_start) >> PAGE_SHIFT;
          for (logic [ADDR_W-1:0] j = 0; j < span; j++) begin
            if (first + j >= NUM_FRAMES) break;
            frame_share_count[first + j] = '0;
          end
        end
      end
      KIND_ALLOC: begin
        if (claim_top_free_frame(claimed_page)) begin
          res.page_addr = claimed_page;
        end else begin
          res.status = ST_OOM;
        end
      end
      KIND_FREE: begin
        idx = (addr - BASE_ADDR) >> PAGE_SHIFT;
        if (addr < BASE_ADDR) begin
          res.status = ST_BELOW;
        end else if (addr > model_mem_end || idx >= NUM_FRAMES) begin
          res.status = ST_NONEXIST;
        end else if (frame_share_count[idx] != '0) begin
          frame_share_count[idx] = frame_share_count[idx] - 8'd1;
        end else begin
          res.status = ST_ALREADY_FREE;
        end
      end
      default: begin
        fault_page = addr & PAGE_MASK;
        tracked    = 1'b0;
        idx        = '0;
        if (fault_page >= BASE_ADDR) begin
          idx     = (fault_page - BASE_ADDR) >> PAGE_SHIFT;
          tracked = idx < NUM_FRAMES;
        end
        if (tracked && frame_share_count[idx] == 8'd1) begin
          // Sole owner: keep the page, just make it writable.
          res.page_addr = fault_page;
          res.status    = ST_IN_PLACE;
        end else if (!claim_top_free_frame(claimed_page)) begin
          res.status = ST_OOM;
        end else begin
          // Drop the old share only after the copy target was claimed.
          if (tracked && frame_share_count[idx] != '0) begin
            frame_share_count[idx] = frame_share_count[idx] - 8'd1;
          end
          res.page_addr = claimed_page;
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready with an optional long hold-off, and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_req_count != stall_ack_count) begin
      stall_ack_count <= stall_req_count;
      stall_left      <= HOLD_OFF_CYCLES;
      m_tready        <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    page_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      status_seen[m_tdata[34:32]]++;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: page_addr_out %h, status %0d",
               m_tdata[31:0], m_tdata[34:32]);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[31:0] !== want.page_addr) begin
          $error("page_addr_out mismatch: expected %h, actual %h",
                 want.page_addr, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[34:32] !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 want.status, m_tdata[34:32]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request, idling at random first, and hold it until accepted.
  task automatic send_request(kind_t kind, logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_page_result(kind, addr));
    requests_by_kind[kind]++;
  endtask

  // Drop the request valid and wait until every result is back.
  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct <= receiver_pct;
  endtask

  // Write both window registers while idle, then mirror them in the model.
  task automatic set_memory_window(logic [ADDR_W-1:0] start_addr,
                                   logic [ADDR_W-1:0] end_addr);
    logic [ADDR_W-1:0] first;
    wait_for_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FREE_START;
    cfg_data  <= start_addr;
    @(posedge clk);
    cfg_index <= CFG_MEM_END;
    cfg_data  <= end_addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_free_start = start_addr;
    model_mem_end    = end_addr;
    first = (start_addr - BASE_ADDR) >> PAGE_SHIFT;
    window_lo_frame = (start_addr >= BASE_ADDR && first < NUM_FRAMES) ?
                      first : NUM_FRAMES - 64;
  endtask

  function automatic logic [ADDR_W-1:0] frame_addr(int unsigned frame);
    return BASE_ADDR + (32'(frame) << PAGE_SHIFT);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight after reset every frame is reserved and end is 0.
  task automatic test_reset_state();
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, 32'h0000_0000);
    send_request(KIND_FREE, BASE_ADDR);        // above end
  endtask

  // Small window at the top of the table: free, fault and exhaustion rules.
  task automatic test_free_and_fault();
    set_memory_window(frame_addr(NUM_FRAMES - 5), TABLE_END);
    send_request(KIND_INIT, $urandom);
    send_request(KIND_ALLOC, $urandom);
    send_request(KIND_ALLOC, $urandom);
    send_request(KIND_FREE, frame_addr(NUM_FRAMES - 1));
    send_request(KIND_FREE, frame_addr(NUM_FRAMES - 1));          // already free
    send_request(KIND_FAULT, frame_addr(NUM_FRAMES - 2) | 32'hFFF); // sole owner
    send_request(KIND_FAULT, frame_addr(0) | 32'h123);            // shared reserved page
    send_request(KIND_FAULT, 32'h0000_0ABC);                      // below base
    send_request(KIND_FAULT, 32'hFFFF_FFFF);                      // past the table
    send_request(KIND_FREE, TABLE_END);                           // beyond table
    send_request(KIND_FREE, BASE_ADDR | 32'hFFF);                 // reserved, decrement
    send_request(KIND_ALLOC, '0);
    send_request(KIND_ALLOC, '0);                                 // out of memory
    send_request(KIND_FAULT, frame_addr(0));                      // fault, no frame left
  endtask

  // Extreme window register values.
  task automatic test_window_extremes();
    set_memory_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // end not above start
    send_request(KIND_INIT, '0);
    send_request(KIND_ALLOC, '0);
    set_memory_window(32'h0000_0000, 32'hFFFF_FFFF);   // start below base
    send_request(KIND_INIT, '0);
    send_request(KIND_ALLOC, '0);
    set_memory_window(BASE_ADDR, 32'hFFFF_FFFF);       // whole table free
    send_request(KIND_INIT, '0);
    send_request(KIND_FREE, 32'hFFFF_FFFF);
  endtask

  // Hold results off for a long stretch while fast requests keep coming,
  // so the block fills up and stalls its request side.
  task automatic test_result_backpressure();
    set_idling(0, 0);
    set_memory_window(frame_addr(NUM_FRAMES - 64), TABLE_END);
    send_request(KIND_INIT, '0);
    // Let the long init sweep finish so the hold-off hits the short requests.
    wait_for_idle();
    stall_req_count <= stall_req_count + 1;
    for (int i = 0; i < 24; i++) begin
      send_request((i % 3 == 0) ? KIND_ALLOC : KIND_FREE,
                   frame_addr($urandom_range(NUM_FRAMES - 1, NUM_FRAMES - 64)));
    end
    wait_for_idle();
  endtask

  // Random phases: a fresh window and init, then mostly well-formed traffic
  // against live frames, with a share of noise addresses.
  task automatic test_random_traffic();
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] addr;
    int unsigned       width;
    int unsigned       lo;
    int unsigned       free_frames;
    int unsigned       roll;
    kind_t             kind;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase / 4)
        0:       set_idling(24, 67);
        1:       set_idling(67, 24);
        default: set_idling(0, 0);
      endcase
      case ($urandom_range(9))
        0: begin
          start_addr = BASE_ADDR;
          end_addr   = 32'hFFFF_FFFF;
        end
        1: begin
          start_addr = $urandom;
          end_addr   = $urandom;
        end
        2: begin
          start_addr = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
          end_addr   = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        end
        default: begin
          // Keep the window near the top so allocation scans stay short.
          width      = $urandom_range(48, 4);
          lo         = NUM_FRAMES - width - $urandom_range(8, 0);
          start_addr = frame_addr(lo) + 32'($urandom_range(4095));
          end_addr   = start_addr + (32'(width) << PAGE_SHIFT) + 32'($urandom_range(4095));
        end
      endcase
      set_memory_window(start_addr, end_addr);
      send_request(KIND_INIT, $urandom);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        free_frames = 0;
        foreach (frame_share_count[j]) if (frame_share_count[j] == '0) free_frames++;
        roll = $urandom_range(99);
        // With nothing free, lean on frees so out-of-memory scans stay rare.
        if (roll < 2) begin
          kind = KIND_INIT;
        end else if (free_frames == 0) begin
          kind = (roll < 8) ? KIND_ALLOC : (roll < 18) ? KIND_FAULT : KIND_FREE;
        end else begin
          kind = (roll < 32) ? KIND_ALLOC : (roll < 72) ? KIND_FREE : KIND_FAULT;
        end
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6:
            addr = frame_addr($urandom_range(NUM_FRAMES - 1, window_lo_frame))
                   + 32'($urandom_range(1) ? $urandom_range(4095) : 0);
          7, 8, 9, 10:
            addr = frame_addr($urandom_range(NUM_FRAMES - 1, 0)) + 32'($urandom_range(4095));
          11, 12:
            addr = $urandom_range(BASE_ADDR - 1, 0);
          13, 14:
            addr = $urandom_range(32'hFFFF_FFFF, TABLE_END);
          15, 16:
            addr = $urandom;
          default:
            addr = model_mem_end + 32'($urandom_range(8191)) - 32'd4096;
        endcase
        send_request(kind, addr);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (frame_share_count[j]) frame_share_count[j] = USED_MARK;
    model_free_start = '0;
    model_mem_end    = '0;
    window_lo_frame  = NUM_FRAMES - 64;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_idling(24, 67);
    test_reset_state();
    test_free_and_fault();
    test_window_extremes();
    test_result_backpressure();
    test_random_traffic();

    // Drain: no idling, wait for every result, then one full scan time more.
    set_idling(0, 0);
    s_tvalid <= 1'b0;
    for (int waited = 0; waited < DRAIN_LIMIT && expected_results.size() != 0;
         waited++) begin
      @(posedge clk);
    end
    repeat (NUM_FRAMES + 8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      $display("FAILURE");
      $finish;
    end

    $display("Covered %0d requests (init %0d, allocate %0d, free %0d, fault %0d), %0d results",
             requests_by_kind[KIND_INIT] + requests_by_kind[KIND_ALLOC] +
             requests_by_kind[KIND_FREE] + requests_by_kind[KIND_FAULT],
             requests_by_kind[KIND_INIT], requests_by_kind[KIND_ALLOC],
             requests_by_kind[KIND_FREE], requests_by_kind[KIND_FAULT], results_checked);
    $display("Statuses: ok %0d, below %0d, nonexistent %0d, freed twice %0d, oom %0d, kept %0d",
             status_seen[ST_OK], status_seen[ST_BELOW], status_seen[ST_NONEXIST],
             status_seen[ST_ALREADY_FREE], status_seen[ST_OOM], status_seen[ST_IN_PLACE]);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/pfra_pkg.sv
rtl/pfra_ram.sv
rtl/pfra_dp.sv
rtl/pfra_ctrl.sv
rtl/page_frame_refcount_allocator.sv
rtl/pfra_checker.sv
sim/page_frame_refcount_allocator_tb.sv
